// ----- hdl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the IPv4 longest-prefix router
// Table geometry, field widths, result codes, the stored route layout and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int PORT_COUNT  = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int PORT_W   = 4;
   localparam int TTL_W    = 8;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

   // Operation codes.
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_FWD = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROP_TTL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // One stored route.
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic              has_hop;
      logic [ADDR_W-1:0] hop_addr;
      logic [PORT_W-1:0] port;
   } route_type;

   localparam int ROUTE_W = $bits(route_type);

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_WAIT,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic add_write;
      logic scan_read;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_fwd;
      logic full;
      logic ttl_low;
      logic table_empty;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   // Mask that keeps the top len bits of an address; a length of zero keeps none.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] shift;
      shift = MAX_LEN - len;
      if (len == '0) begin
         return '0;
      end
      return {ADDR_W{1'b1}} << shift;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lpr_ram.sv -----
// ----------------------------------------------------------------------------
// lpr_ram: generic single-port-write, single-port-read memory
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/lpr_datapath.sv -----
// ----------------------------------------------------------------------------
// lpr_datapath: route table, match comparator and result register
// Holds the request, the route count and the table memory, compares one stored
// route per cycle against the destination and keeps the best match so far.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_datapath
   import lpr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output      dp_status_type       status,
   input  wire logic                req_op,
   input  wire logic [ADDR_W-1:0]   req_entry_prefix,
   input  wire logic [LEN_W-1:0]    req_entry_length,
   input  wire logic                req_entry_has_hop,
   input  wire logic [ADDR_W-1:0]   req_entry_hop_addr,
   input  wire logic [PORT_W-1:0]   req_entry_port,
   input  wire logic [ADDR_W-1:0]   req_dest_addr,
   input  wire logic [TTL_W-1:0]    req_hop_limit,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [PORT_W-1:0]   rsp_out_port,
   output      logic [ADDR_W-1:0]   rsp_hop_addr_out,
   output      logic [TTL_W-1:0]    rsp_new_hop_limit
);

   // Captured request.
   logic              op_ff;
   route_type         entry_ff,  entry_in;
   logic [ADDR_W-1:0] dest_ff;
   logic [TTL_W-1:0]  ttl_ff;
   logic              full_ff,   full_in;

   // Table bookkeeping and scan.
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [IDX_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              rd_valid_ff, rd_valid_in;
   route_type         rd_route;

   // Best match so far.
   logic              found_ff,  found_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [PORT_W-1:0] best_port_ff, best_port_in;
   logic              best_has_hop_ff, best_has_hop_in;
   logic [ADDR_W-1:0] best_hop_ff, best_hop_in;

   // Result register.
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PORT_W-1:0]   rsp_port_ff,   rsp_port_in;
   logic [ADDR_W-1:0]   rsp_hop_ff,    rsp_hop_in;
   logic [TTL_W-1:0]    rsp_ttl_ff,    rsp_ttl_in;

   logic                ttl_low;
   logic                hit;
   logic                take;
   logic                port_bad;
   logic [STATUS_W-1:0] res_status;

   lpr_ram #(
      .WIDTH (ROUTE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.add_write),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (entry_ff),
      .rd_en   (cmd.scan_read),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_route)
   );

   assign ttl_low  = (ttl_ff <= TTL_W'(1));
   assign hit      = ((dest_ff ^ rd_route.prefix) & prefix_mask(rd_route.length)) == '0;
   assign take     = rd_valid_ff && hit && (!found_ff || (rd_route.length >= best_len_ff));
   assign port_bad = ({1'b0, best_port_ff} >= (PORT_W + 1)'(PORT_COUNT));

   always_comb begin
      entry_in          = entry_ff;
      entry_in.prefix   = req_entry_prefix;
      entry_in.length   = (req_entry_length > MAX_LEN) ? MAX_LEN : req_entry_length;
      entry_in.has_hop  = req_entry_has_hop;
      entry_in.hop_addr = req_entry_hop_addr;
      entry_in.port     = req_entry_port;
      full_in           = (count_ff == CNT_W'(TABLE_DEPTH));

      count_in = count_ff;
      if (cmd.add_write) begin
         count_in = count_ff + CNT_W'(1);
      end

      scan_addr_in = scan_addr_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
      end else if (cmd.scan_read) begin
         scan_addr_in = scan_addr_ff + IDX_W'(1);
      end
      rd_valid_in = cmd.scan_read;

      found_in        = found_ff;
      best_len_in     = best_len_ff;
      best_port_in    = best_port_ff;
      best_has_hop_in = best_has_hop_ff;
      best_hop_in     = best_hop_ff;
      if (cmd.load) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in        = 1'b1;
         best_len_in     = rd_route.length;
         best_port_in    = rd_route.port;
         best_has_hop_in = rd_route.has_hop;
         best_hop_in     = rd_route.hop_addr;
      end

      if (op_ff == OP_ADD) begin
         res_status = full_ff ? ST_FULL : ST_ADDED;
      end else if (ttl_low) begin
         res_status = ST_DROP_TTL;
      end else if (!found_ff || port_bad) begin
         res_status = ST_NO_ROUTE;
      end else begin
         res_status = ST_FORWARDED;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_ttl_in    = rsp_ttl_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_port_in   = '0;
         rsp_hop_in    = '0;
         rsp_ttl_in    = '0;
         if (res_status == ST_FORWARDED) begin
            rsp_port_in = best_port_ff;
            rsp_hop_in  = best_has_hop_ff ? best_hop_ff : dest_ff;
            rsp_ttl_in  = ttl_ff - TTL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         entry_ff <= entry_in;
         dest_ff  <= req_dest_addr;
         ttl_ff   <= req_hop_limit;
         full_ff  <= full_in;
      end
      best_len_ff     <= best_len_in;
      best_port_ff    <= best_port_in;
      best_has_hop_ff <= best_has_hop_in;
      best_hop_ff     <= best_hop_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_port_ff     <= rsp_port_in;
      rsp_hop_ff      <= rsp_hop_in;
      rsp_ttl_ff      <= rsp_ttl_in;
   end

   assign status.op_fwd      = (op_ff == OP_FWD);
   assign status.full        = full_ff;
   assign status.ttl_low     = ttl_low;
   assign status.table_empty = (count_ff == '0);
   assign status.scan_last   = ((CNT_W'(scan_addr_ff) + CNT_W'(1)) == count_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_port      = rsp_port_ff;
   assign rsp_hop_addr_out  = rsp_hop_ff;
   assign rsp_new_hop_limit = rsp_ttl_ff;

endmodule

`default_nettype wire

// ----- hdl/lpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpr_ctrl: sequencing state machine for the IPv4 longest-prefix router
// Takes a request, decides between add, drop and table scan, walks the scan
// one entry per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ctrl
   import lpr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type status,
   output      cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.op_fwd) begin
               cmd.add_write = !status.full;
               state_in      = S_DONE;
            end else if (status.ttl_low || status.table_empty) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // The last entry read is compared in this cycle.
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/ipv4_longest_prefix_router.sv -----
// An add, a TTL drop or an empty-table forward goes from request capture through
// decode to the result step; others also walk the route scan and a wait step.
// A new request is taken only in idle; the result step waits for a free result
// register, and the scan walks the single table read port one entry per cycle.
// Reset clears the route count and the control state; the table memory is not
// cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router: IPv4 longest-prefix-match forwarding block
// Keeps a table of routes, appends routes on add requests and resolves the
// outgoing interface and next hop of forwarded datagrams.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_longest_prefix_router
   import lpr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_op,
   input  wire logic [ADDR_W-1:0]   req_entry_prefix,
   input  wire logic [LEN_W-1:0]    req_entry_length,
   input  wire logic                req_entry_has_hop,
   input  wire logic [ADDR_W-1:0]   req_entry_hop_addr,
   input  wire logic [PORT_W-1:0]   req_entry_port,
   input  wire logic [ADDR_W-1:0]   req_dest_addr,
   input  wire logic [TTL_W-1:0]    req_hop_limit,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [PORT_W-1:0]   rsp_out_port,
   output      logic [ADDR_W-1:0]   rsp_hop_addr_out,
   output      logic [TTL_W-1:0]    rsp_new_hop_limit
);

   // The controller sequences each request: it captures the transfer, decides
   // whether the request is an add, a drop or a table scan, and steps the scan
   // address one route per cycle. The datapath owns the route memory, the
   // prefix comparator and the best-match registers. Routes are appended in
   // order, and a later route of equal length replaces the current best, so
   // ties go to the route added last.
   cmd_type       cmd;
   dp_status_type status;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register sits at the datapath output, so a new request is
   // taken while a finished result still waits for its transfer; only the
   // final step of the next request stalls until the register is free.
   lpr_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_entry_prefix   (req_entry_prefix),
      .req_entry_length   (req_entry_length),
      .req_entry_has_hop  (req_entry_has_hop),
      .req_entry_hop_addr (req_entry_hop_addr),
      .req_entry_port     (req_entry_port),
      .req_dest_addr      (req_dest_addr),
      .req_hop_limit      (req_hop_limit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_port       (rsp_out_port),
      .rsp_hop_addr_out   (rsp_hop_addr_out),
      .rsp_new_hop_limit  (rsp_new_hop_limit)
   );

endmodule

`default_nettype wire

// ----- hdl/lpr_checker.sv -----
// ----------------------------------------------------------------------------
// lpr_checker: port-level assertions for the IPv4 longest-prefix router
// Watches the result channel for stability, legal codes, cleared fields and TTL.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_checker
   import lpr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [PORT_W-1:0]   rsp_out_port,
   input wire logic [ADDR_W-1:0]   rsp_hop_addr_out,
   input wire logic [TTL_W-1:0]    rsp_new_hop_limit
);

   // A stalled result holds its value.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_out_port) && $stable(rsp_hop_addr_out) && $stable(rsp_new_hop_limit))
      else $error("result changed while stalled");

   // No result is pending in the cycle after reset.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A presented result always carries a defined status code.
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL))
      else $error("undefined status code");

   // Drops and adds carry cleared fields.
   a_clear_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FORWARDED) |->
         (rsp_out_port == '0) && (rsp_hop_addr_out == '0) && (rsp_new_hop_limit == '0))
      else $error("non-forwarded result carries data");

   // A forwarded datagram left with a TTL of at least one, and while it is shown the
   // block never takes back-to-back requests, since it is ready only when idle.
   a_fwd_ttl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FORWARDED) |-> (rsp_new_hop_limit != '0) &&
         !(req_valid && req_ready && $past(req_valid && req_ready)))
      else $error("forwarded result with expired TTL");

endmodule

bind ipv4_longest_prefix_router lpr_checker u_lpr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_out_port      (rsp_out_port),
   .rsp_hop_addr_out  (rsp_hop_addr_out),
   .rsp_new_hop_limit (rsp_new_hop_limit)
);

`default_nettype wire

// ----- tb/lpr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_scoreboard: result checker for the IPv4 longest-prefix router
// Watches both channels, keeps its own route table, predicts the result of
// every accepted request and compares it with the responses in order.
// ----------------------------------------------------------------------------

module lpr_scoreboard
   import lpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_entry_prefix,
   input  logic [LEN_W-1:0]    req_entry_length,
   input  logic                req_entry_has_hop,
   input  logic [ADDR_W-1:0]   req_entry_hop_addr,
   input  logic [PORT_W-1:0]   req_entry_port,
   input  logic [ADDR_W-1:0]   req_dest_addr,
   input  logic [TTL_W-1:0]    req_hop_limit,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [PORT_W-1:0]   rsp_out_port,
   input  logic [ADDR_W-1:0]   rsp_hop_addr_out,
   input  logic [TTL_W-1:0]    rsp_new_hop_limit,
   output int unsigned         mismatches,
   output int unsigned         awaited_count,
   output int unsigned         results_seen
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PORT_W-1:0]   port;
      logic [ADDR_W-1:0]   hop;
      logic [TTL_W-1:0]    ttl;
   } verdict_type;

   route_type   routes [TABLE_DEPTH];
   int unsigned route_count;
   verdict_type awaited [$];

   // Applies one request to the shadow table and returns its outcome.
   function automatic verdict_type route_outcome(
      input logic              op,
      input logic [ADDR_W-1:0] prefix,
      input logic [LEN_W-1:0]  length,
      input logic              has_hop,
      input logic [ADDR_W-1:0] hop_addr,
      input logic [PORT_W-1:0] port,
      input logic [ADDR_W-1:0] dest,
      input logic [TTL_W-1:0]  ttl
   );
      verdict_type       v;
      logic              found;
      int unsigned       best;
      int unsigned       best_len;
      int unsigned       len;
      logic [ADDR_W-1:0] mask;
      v = '0;
      found = 1'b0;
      best = 0;
      best_len = 0;
      if (op == OP_ADD) begin
         if (route_count >= TABLE_DEPTH) begin
            v.status = ST_FULL;
         end else begin
            routes[route_count].prefix   = prefix;
            routes[route_count].length   = (length > MAX_LEN) ? MAX_LEN : length;
            routes[route_count].has_hop  = has_hop;
            routes[route_count].hop_addr = hop_addr;
            routes[route_count].port     = port;
            route_count++;
            v.status = ST_ADDED;
         end
         return v;
      end
      if (ttl <= 1) begin
         v.status = ST_DROP_TTL;
         return v;
      end
      for (int i = 0; i < route_count; i++) begin
         len = routes[i].length;
         mask = (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
         // The later of two equally long matches wins, hence >=.
         if (((dest & mask) == (routes[i].prefix & mask)) && (!found || len >= best_len)) begin
            found = 1'b1;
            best = i;
            best_len = len;
         end
      end
      if (!found || routes[best].port >= PORT_COUNT) begin
         v.status = ST_NO_ROUTE;
      end else begin
         v.status = ST_FORWARDED;
         v.port   = routes[best].port;
         v.hop    = routes[best].has_hop ? routes[best].hop_addr : dest;
         v.ttl    = ttl - 1'b1;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         route_count = 0;
         awaited.delete();
         mismatches = 0;
         results_seen = 0;
         awaited_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited = {awaited, route_outcome(req_op, req_entry_prefix, req_entry_length,
               req_entry_has_hop, req_entry_hop_addr, req_entry_port, req_dest_addr,
               req_hop_limit)};
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_out_port, rsp_hop_addr_out, rsp_new_hop_limit};
            results_seen++;
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result, status %0d port %0d hop %h ttl %0d",
                     $realtime, got.status, got.port, got.hop, got.ttl);
               end
            end else begin
               want = awaited.pop_front();
               if (got.status !== want.status || got.port !== want.port ||
                   got.hop !== want.hop || got.ttl !== want.ttl) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result %0d differs (expected/actual): status %0d/%0d",
                        $realtime, results_seen, want.status, got.status);
                     $display("   port %0d/%0d hop %h/%h ttl %0d/%0d", want.port, got.port,
                        want.hop, got.hop, want.ttl, got.ttl);
                  end
               end
            end
         end
         awaited_count <= awaited.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the IPv4 longest-prefix router
// Drives route adds and datagram forwards with random idling on both sides,
// while a checker beside the router predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
   import lpr_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OP_ADD;
   logic [ADDR_W-1:0]   req_entry_prefix = '0;
   logic [LEN_W-1:0]    req_entry_length = '0;
   logic                req_entry_has_hop = 1'b0;
   logic [ADDR_W-1:0]   req_entry_hop_addr = '0;
   logic [PORT_W-1:0]   req_entry_port = '0;
   logic [ADDR_W-1:0]   req_dest_addr = '0;
   logic [TTL_W-1:0]    req_hop_limit = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PORT_W-1:0]   rsp_out_port;
   logic [ADDR_W-1:0]   rsp_hop_addr_out;
   logic [TTL_W-1:0]    rsp_new_hop_limit;

   int unsigned mismatches;
   int unsigned awaited_count;
   int unsigned results_seen;

   // While calm is set, neither side idles.
   logic calm = 1'b0;

   // Routes actually stored, used to aim destinations and report table size.
   logic [ADDR_W-1:0] known_prefix [$];
   int unsigned       known_len [$];

   int unsigned add_count;
   int unsigned forward_count;
   int unsigned low_ttl_count;

   ipv4_longest_prefix_router dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_entry_prefix  (req_entry_prefix),
      .req_entry_length  (req_entry_length),
      .req_entry_has_hop (req_entry_has_hop),
      .req_entry_hop_addr(req_entry_hop_addr),
      .req_entry_port    (req_entry_port),
      .req_dest_addr     (req_dest_addr),
      .req_hop_limit     (req_hop_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_port      (rsp_out_port),
      .rsp_hop_addr_out  (rsp_hop_addr_out),
      .rsp_new_hop_limit (rsp_new_hop_limit)
   );

   lpr_scoreboard u_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_entry_prefix  (req_entry_prefix),
      .req_entry_length  (req_entry_length),
      .req_entry_has_hop (req_entry_has_hop),
      .req_entry_hop_addr(req_entry_hop_addr),
      .req_entry_port    (req_entry_port),
      .req_dest_addr     (req_dest_addr),
      .req_hop_limit     (req_hop_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_port      (rsp_out_port),
      .rsp_hop_addr_out  (rsp_hop_addr_out),
      .rsp_new_hop_limit (rsp_new_hop_limit),
      .mismatches        (mismatches),
      .awaited_count     (awaited_count),
      .results_seen      (results_seen)
   );

   always #4 clock = ~clock;

   // The receiver stalls with a chance of roughly 30 percent, except while calm.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 30);
   end

   // Offers one request and holds it until the transfer. An optional gap
   // before it drops valid first, outside calm; otherwise valid stays high from
   // the previous transfer, so valid sees only one update per edge.
   task automatic send(
      input logic              op,
      input logic [ADDR_W-1:0] prefix,
      input logic [LEN_W-1:0]  length,
      input logic              has_hop,
      input logic [ADDR_W-1:0] hop_addr,
      input logic [PORT_W-1:0] port,
      input logic [ADDR_W-1:0] dest,
      input logic [TTL_W-1:0]  ttl
   );
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_entry_prefix   <= prefix;
      req_entry_length   <= length;
      req_entry_has_hop  <= has_hop;
      req_entry_hop_addr <= hop_addr;
      req_entry_port     <= port;
      req_dest_addr      <= dest;
      req_hop_limit      <= ttl;
      do @(posedge clock); while (!req_ready);
      if (op == OP_ADD) begin
         add_count++;
      end else begin
         forward_count++;
         if (ttl <= 1) begin
            low_ttl_count++;
         end
      end
   endtask

   // Adds a route. The forward fields carry random junk, which the router
   // must ignore. A route that fits in the table is remembered for aiming.
   task automatic install_route(
      input logic [ADDR_W-1:0] prefix,
      input logic [LEN_W-1:0]  length,
      input logic              has_hop,
      input logic [ADDR_W-1:0] hop_addr,
      input logic [PORT_W-1:0] port
   );
      int unsigned eff_len;
      eff_len = (length > MAX_LEN) ? MAX_LEN : length;
      if (known_prefix.size() < TABLE_DEPTH) begin
         known_prefix = {known_prefix, prefix};
         known_len    = {known_len, eff_len};
      end
      send(OP_ADD, prefix, length, has_hop, hop_addr, port, $urandom, TTL_W'($urandom));
   endtask

   task automatic forward(input logic [ADDR_W-1:0] dest, input logic [TTL_W-1:0] ttl);
      send(OP_FWD, $urandom, LEN_W'($urandom), 1'($urandom), $urandom, PORT_W'($urandom),
         dest, ttl);
   endtask

   // Stops sending until every outstanding result has been taken. The first
   // edge lets the checker's count take in the transfer just made.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // Picks an address inside a stored route, with random bits below its prefix.
   function automatic logic [ADDR_W-1:0] aim_at_route();
      int unsigned       k;
      logic [ADDR_W-1:0] mask;
      if (known_prefix.size() == 0) begin
         return $urandom;
      end
      k = $urandom_range(0, known_prefix.size() - 1);
      if (known_len[k] == 0) begin
         return $urandom;
      end
      mask = {ADDR_W{1'b1}} << (ADDR_W - known_len[k]);
      return (known_prefix[k] & mask) | ($urandom & ~mask);
   endfunction

   // Most destinations land inside some route; some are one bit off, which
   // often falls back to a shorter route, and the rest are arbitrary.
   function automatic logic [ADDR_W-1:0] pick_dest();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return aim_at_route();
      end else if (r < 80) begin
         return aim_at_route() ^ (32'h1 << $urandom_range(0, 31));
      end
      return $urandom;
   endfunction

   function automatic logic [TTL_W-1:0] pick_ttl();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         return 8'd0;
      end else if (r < 8) begin
         return 8'd1;
      end else if (r < 12) begin
         return 8'd255;
      end else if (r < 15) begin
         return 8'd2;
      end
      return TTL_W'($urandom_range(2, 254));
   endfunction

   initial begin
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      int unsigned       guard;
      add_count = 0;
      forward_count = 0;
      low_ttl_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty table finds no route, and low TTLs are
      // dropped before any search.
      forward(32'hC0A8_0101, 8'd64);
      forward(32'h0A01_0203, 8'd0);
      forward(32'h0A01_0203, 8'd1);
      // A /8 route with a next hop, reached with the smallest TTL that still
      // forwards; a destination outside it has no route yet.
      install_route(32'h0A00_0000, 6'd8, 1'b1, 32'hAC10_0001, 4'd1);
      forward(32'h0A01_0203, 8'd2);
      forward(32'h0B00_0001, 8'd255);
      // A default route matches everything, whatever its prefix bits say, and
      // being directly attached it hands back the destination itself.
      install_route(32'hFFFF_FFFF, 6'd0, 1'b0, 32'hFFFF_FFFF, 4'd15);
      forward(32'h0B00_0001, 8'd255);
      // Two /16 routes of equal length: the one added later must win.
      install_route(32'h0A01_0000, 6'd16, 1'b0, 32'h0000_0000, 4'd2);
      install_route(32'h0A01_0000, 6'd16, 1'b1, 32'hFFFF_FFFF, 4'd3);
      forward(32'h0A01_FFFF, 8'd128);
      // Lengths above 32 are saturated to a host route.
      install_route(32'hFFFF_FFFF, 6'd40, 1'b1, 32'h0000_0000, 4'd4);
      forward(32'hFFFF_FFFF, 8'd3);
      install_route(32'h0000_0000, 6'd63, 1'b1, 32'h5A5A_A5A5, 4'd0);
      forward(32'h0000_0000, 8'd10);

      // Fill the rest of the table, partly with routes nested in earlier
      // ones, and then knock on the full table once.
      for (int j = 0; j < 10; j++) begin
         prefix = $urandom_range(0, 1) ? aim_at_route() : $urandom;
         length = (j < 2) ? LEN_W'($urandom_range(33, 63)) : LEN_W'($urandom_range(1, 32));
         install_route(prefix, length, 1'($urandom), $urandom, PORT_W'($urandom));
      end
      install_route($urandom, LEN_W'($urandom), 1'($urandom), $urandom, PORT_W'($urandom));
      drain();

      // Random part: mostly forwards through the full table, with an
      // occasional add that must bounce off it.
      for (int i = 0; i < 1200; i++) begin
         if (i == 300) begin
            calm <= 1'b1;
         end
         if (i == 550) begin
            calm <= 1'b0;
         end
         if (i == 800) begin
            drain();
         end
         if ($urandom_range(0, 99) < 5) begin
            install_route($urandom, LEN_W'($urandom), 1'($urandom), $urandom,
               PORT_W'($urandom));
         end else begin
            forward(pick_dest(), pick_ttl());
         end
      end
      req_valid <= 1'b0;

      // Wait for the last results, then give a straggler time to show up.
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (awaited_count != 0 && guard < 5000);
      repeat (25) @(posedge clock);

      if (awaited_count != 0) begin
         $display("%0d results never arrived", awaited_count);
      end
      $display("Sent %0d requests: %0d route adds, %0d forwards (%0d with TTL 0 or 1).",
         add_count + forward_count, add_count, forward_count, low_ttl_count);
      $display("Checked %0d results against a table of %0d routes; %0d mismatches.",
         results_seen, known_prefix.size(), mismatches);
      if (mismatches == 0 && awaited_count == 0) begin
         $display("[ipv4_longest_prefix_router] OK");
      end else begin
         $display("[ipv4_longest_prefix_router] ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Timeout with %0d results outstanding", awaited_count);
      $display("[ipv4_longest_prefix_router] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lpr_pkg.sv
hdl/lpr_ram.sv
hdl/lpr_datapath.sv
hdl/lpr_ctrl.sv
hdl/ipv4_longest_prefix_router.sv
hdl/lpr_checker.sv
tb/lpr_checker.sv
tb/tb.sv
